// ===== hw/rtl/aesctr_pkg.sv =====
package aesctr_pkg;

    localparam int unsigned BlkW = 128;
    localparam int unsigned WordW = 64;
    localparam int unsigned NumRounds = 10;
    localparam int unsigned CntW = 7;

    typedef logic [BlkW-1:0] t_block;
    typedef logic [3:0] t_round;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_KEY_LOW  = 1'b0,
        REG_KEY_HIGH = 1'b1
    } t_reg_idx;

    localparam logic KIND_SINGLE = 1'b0;
    localparam logic KIND_CTR    = 1'b1;

    // one classified request between the front and the back
    typedef struct packed {
        logic           kind;
        logic [WordW-1:0] word_lo;
        logic [WordW-1:0] word_hi;
        logic [CntW-1:0]  count;
    } t_job;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] rcon(input t_round r);
        logic [7:0] v;
        case (r)
            4'd1: v = 8'h01;
            4'd2: v = 8'h02;
            4'd3: v = 8'h04;
            4'd4: v = 8'h08;
            4'd5: v = 8'h10;
            4'd6: v = 8'h20;
            4'd7: v = 8'h40;
            4'd8: v = 8'h80;
            4'd9: v = 8'h1b;
            4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // next round key from the previous one, byte n at bits 8n
    function automatic t_block next_key(input t_block k, input t_round r);
        t_block o;
        logic [31:0] t;
        t = {sbox(k[103:96]), sbox(k[127:120]), sbox(k[119:112]),
             sbox(k[111:104]) ^ rcon(r)};
        o[31:0]   = k[31:0] ^ t;
        o[63:32]  = k[63:32] ^ o[31:0];
        o[95:64]  = k[95:64] ^ o[63:32];
        o[127:96] = k[127:96] ^ o[95:64];
        return o;
    endfunction

    // one full round; final round skips mix columns
    function automatic t_block aes_round(input t_block s, input t_block k, input logic fin);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        t_block o;
        for (int n = 0; n < 16; n++) b[n] = sbox(s[8*n +: 8]);
        for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++) t[w + 4*c] = b[w + 4*((c + w) & 3)];
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (fin) begin
                o[32*c +: 32] = {a3, a2, a1, a0};
            end else begin
                o[32*c +: 32] = {a3 ^ al ^ xtime(a3 ^ a0), a2 ^ al ^ xtime(a2 ^ a3),
                                 a1 ^ al ^ xtime(a1 ^ a2), a0 ^ al ^ xtime(a0 ^ a1)};
            end
        end
        return o ^ k;
    endfunction

endpackage

// ===== hw/rtl/aes128_block_and_counter_encryptor_unit.sv =====
// AES-128 encryptor with a counter-run mode. The key is written through
// i_cfg_we / i_cfg_idx / i_cfg_data (index 0 low half, 1 high half); each
// write restarts the round key expansion, during which no block is
// started. Kind 0 encrypts one block; kind 1 encrypts block_count (capped
// at 64 and at MAX_RUN) counter blocks, base+i in both halves, with o_last
// on the final one. A front queue of two requests accepts input while the
// back end works. Each block runs through one round register, one round
// per cycle. The result waits in one output register, and the next block
// starts no earlier than the cycle after that result is popped.
module aes128_block_and_counter_encryptor_unit #(
    parameter int MAX_RUN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        i_kind,
    input  logic [63:0] i_plain_low,
    input  logic [63:0] i_plain_high,
    input  logic [63:0] i_base_index,
    input  logic [6:0]  i_block_count,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_cipher_low,
    output logic [63:0] o_cipher_high,
    output logic        o_last
);
    import aesctr_pkg::*;

    t_job   w_job;
    logic   w_jv, w_take, w_kbusy;
    t_block w_rkey;
    t_round r_rnd;
    t_block r_st;
    logic   r_act;
    logic [6:0] r_idx;
    logic [6:0] w_cnt;
    logic [63:0] w_ctr;
    logic   r_ov;

    // run length capped at the parameter
    assign w_cnt = (w_job.count > 7'(MAX_RUN)) ? 7'(MAX_RUN) : w_job.count;
    assign w_ctr = w_job.word_lo + {57'd0, r_idx};

    aesctr_keys u_keys (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(i_cfg_we), .i_idx(i_cfg_idx[0]),
        .i_data(i_cfg_data), .i_rd_round(r_act ? r_rnd : 4'd0),
        .o_rd_key(w_rkey), .o_busy(w_kbusy)
    );

    aesctr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_kind(i_kind), .i_plain_low(i_plain_low), .i_plain_high(i_plain_high),
        .i_base_index(i_base_index), .i_block_count(i_block_count),
        .o_job(w_job), .o_valid(w_jv), .i_take(w_take)
    );

    // last block of the job leaves its queue entry when it finishes
    logic w_fin, w_lastblk;
    assign w_fin     = r_act && (r_rnd == t_round'(NumRounds)) && !r_ov;
    assign w_lastblk = (r_idx + 7'd1 == w_cnt);
    assign w_take    = w_fin && w_lastblk;
    assign empty     = !r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_rnd <= '0;
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (r_ov && pop) r_ov <= 1'b0;
            if (!r_act) begin
                // start a block: whitening with round key 0
                if (w_jv && !w_kbusy && !r_ov) begin
                    r_st  <= ((w_job.kind == KIND_CTR) ? {w_ctr, w_ctr}
                             : {w_job.word_hi, w_job.word_lo}) ^ w_rkey;
                    r_rnd <= 4'd1;
                    r_act <= 1'b1;
                end
            end else if (r_rnd != t_round'(NumRounds)) begin
                r_st  <= aes_round(r_st, w_rkey, 1'b0);
                r_rnd <= r_rnd + 4'd1;
            end else if (!r_ov) begin
                {o_cipher_high, o_cipher_low} <= aes_round(r_st, w_rkey, 1'b1);
                o_last <= w_lastblk;
                r_ov   <= 1'b1;
                r_act  <= 1'b0;
                r_rnd  <= '0;
                r_idx  <= w_lastblk ? 7'd0 : r_idx + 7'd1;
            end
        end
    end
endmodule

// ===== hw/rtl/aesctr_keys.sv =====
module aesctr_keys (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic                  i_idx,
    input  logic [63:0]           i_data,
    input  aesctr_pkg::t_round    i_rd_round,
    output aesctr_pkg::t_block    o_rd_key,
    output logic                  o_busy
);
    import aesctr_pkg::*;

    // round key store, filled one round per cycle after a key write
    t_block r_store [NumRounds+1];
    t_block r_key;
    t_block r_work;
    t_round r_cnt;
    logic   r_busy;
    logic   r_seeded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key    <= '0;
            r_cnt    <= '0;
            r_busy   <= 1'b1;
            r_seeded <= 1'b0;
        end else begin
            if (i_we) begin
                if (i_idx == REG_KEY_LOW) r_key[63:0] <= i_data;
                else r_key[127:64] <= i_data;
                r_busy   <= 1'b1;
                r_seeded <= 1'b0;
                r_cnt    <= '0;
            end else if (r_busy) begin
                if (!r_seeded) begin
                    r_store[0] <= r_key;
                    r_work     <= r_key;
                    r_seeded   <= 1'b1;
                    r_cnt      <= 4'd1;
                end else begin
                    r_work         <= next_key(r_work, r_cnt);
                    r_store[r_cnt] <= next_key(r_work, r_cnt);
                    if (r_cnt == t_round'(NumRounds)) r_busy <= 1'b0;
                    r_cnt <= r_cnt + 4'd1;
                end
            end
        end
    end

    assign o_rd_key = r_store[i_rd_round];
    assign o_busy   = r_busy;
endmodule

// ===== hw/rtl/aesctr_front.sv =====
module aesctr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic                i_kind,
    input  logic [63:0]         i_plain_low,
    input  logic [63:0]         i_plain_high,
    input  logic [63:0]         i_base_index,
    input  logic [6:0]          i_block_count,
    output aesctr_pkg::t_job    o_job,
    output logic                o_valid,
    input  logic                i_take
);
    import aesctr_pkg::*;

    // two-entry job queue
    t_job   r_q [2];
    logic   r_wp, r_rp;
    logic [1:0] r_n;
    t_job   w_job;
    logic   w_push, w_pop;

    always_comb begin
        w_job.kind    = i_kind;
        w_job.word_lo = (i_kind == KIND_CTR) ? i_base_index : i_plain_low;
        w_job.word_hi = (i_kind == KIND_CTR) ? i_base_index : i_plain_high;
        w_job.count   = (i_kind == KIND_SINGLE) ? 7'd1 :
                        (i_block_count > 7'd64) ? 7'd64 : i_block_count;
    end

    assign o_full  = r_n[1];
    assign o_valid = (r_n != 2'd0);
    assign o_job   = r_q[r_rp];
    assign w_push  = i_push && !o_full && (w_job.count != '0);
    assign w_pop   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_n  <= '0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_job;
                r_wp <= ~r_wp;
            end
            if (w_pop) r_rp <= ~r_rp;
            r_n <= r_n + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
